@@ sv/ttw_pkg.sv @@
// Package: types, constants and glyph mapping for the word-wrap layout block.
package ttw_pkg;

  localparam int MaxWidth = 32;
  localparam int IdxW     = $clog2(MaxWidth);

  localparam logic [2:0] RegLeft   = 3'd0;
  localparam logic [2:0] RegTop    = 3'd1;
  localparam logic [2:0] RegWidth  = 3'd2;
  localparam logic [2:0] RegHeight = 3'd3;
  localparam logic [2:0] RegPCol   = 3'd4;
  localparam logic [2:0] RegPRow   = 3'd5;
  localparam logic [2:0] RegPEn    = 3'd6;
  localparam logic [2:0] RegBreak  = 3'd7;

  localparam logic [7:0]  ChSpace   = 8'h20;
  localparam logic [7:0]  ChCr      = 8'd13;
  localparam logic [7:0]  ChLf      = 8'd10;
  localparam logic [7:0]  ChNul     = 8'd0;
  localparam logic [13:0] GlyphLow  = 14'h1000;
  localparam logic [13:0] GlyphHigh = 14'h3000;
  localparam logic [13:0] GlyphUnk  = 14'd999;

  typedef struct packed {
    logic [7:0] area_left;
    logic [7:0] area_top;
    logic [5:0] area_width;
    logic [7:0] area_height;
    logic [7:0] probe_col;
    logic [7:0] probe_row;
    logic       probe_enable;
    logic       after_break;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [5:0]  run_cols;
    logic [7:0]  run_rows;
    logic [13:0] glyph_code;
    logic        page_done;
    logic [31:0] next_offset;
    logic        probe_found;
    logic [31:0] probe_offset;
  } res_t;

  function automatic logic [13:0] glyph_of(input logic [7:0] b);
    logic [13:0] g;
    g = GlyphUnk;
    if (b >= 8'h30 && b <= 8'h39) g = 14'(b - 8'h30) + 14'd10;
    else if (b >= 8'h61 && b <= 8'h7a) g = GlyphLow + {5'd0, 5'(b - 8'h61), 4'd0};
    else if (b >= 8'h41 && b <= 8'h5a) g = GlyphHigh + {5'd0, 5'(b - 8'h41), 4'd0};
    else begin
      unique case (b)
        8'h20:   g = 14'd0;
        8'h5f:   g = 14'd1;
        8'h2d:   g = 14'd2;
        8'h2e:   g = 14'd3;
        8'h2c:   g = 14'd4;
        8'h2f:   g = 14'd5;
        8'h5c:   g = 14'd6;
        8'h3a:   g = 14'd7;
        8'h3b:   g = 14'd8;
        8'h40:   g = 14'd9;
        default: g = GlyphUnk;
      endcase
    end
    return g;
  endfunction

endpackage

@@ sv/ttw_if.sv @@
// Interfaces: input byte channel and result channel.
interface ttw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       begin_page;
  modport source (output valid, text_byte, begin_page, input ready);
  modport sink (input valid, text_byte, begin_page, output ready);
endinterface

interface ttw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_col;
  logic [7:0]  cell_row;
  logic [5:0]  run_cols;
  logic [7:0]  run_rows;
  logic [13:0] glyph_code;
  logic        page_done;
  logic [31:0] next_offset;
  logic        probe_found;
  logic [31:0] probe_offset;
  logic        run_last;
  modport source (output valid, cell_col, cell_row, run_cols, run_rows, glyph_code,
                  page_done, next_offset, probe_found, probe_offset, run_last,
                  input ready);
  modport sink (input valid, cell_col, cell_row, run_cols, run_rows, glyph_code,
                page_done, next_offset, probe_found, probe_offset, run_last,
                output ready);
endinterface

@@ sv/ttw_cfg.sv @@
// Configuration register file behind the APB-style port.
module ttw_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output ttw_pkg::cfg_t  cfg_o
);

  ttw_pkg::cfg_t cfg_q;
  logic [2:0]    idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_left    <= 8'd0;
      cfg_q.area_top     <= 8'd0;
      cfg_q.area_width   <= 6'd16;
      cfg_q.area_height  <= 8'd1;
      cfg_q.probe_col    <= 8'd0;
      cfg_q.probe_row    <= 8'd0;
      cfg_q.probe_enable <= 1'b0;
      cfg_q.after_break  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ttw_pkg::RegLeft:   cfg_q.area_left    <= pwdata[7:0];
        ttw_pkg::RegTop:    cfg_q.area_top     <= pwdata[7:0];
        ttw_pkg::RegWidth:  cfg_q.area_width   <= pwdata[5:0];
        ttw_pkg::RegHeight: cfg_q.area_height  <= pwdata[7:0];
        ttw_pkg::RegPCol:   cfg_q.probe_col    <= pwdata[7:0];
        ttw_pkg::RegPRow:   cfg_q.probe_row    <= pwdata[7:0];
        ttw_pkg::RegPEn:    cfg_q.probe_enable <= pwdata[0];
        ttw_pkg::RegBreak:  cfg_q.after_break  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttw_pkg::RegLeft:   prdata = {24'd0, cfg_q.area_left};
      ttw_pkg::RegTop:    prdata = {24'd0, cfg_q.area_top};
      ttw_pkg::RegWidth:  prdata = {26'd0, cfg_q.area_width};
      ttw_pkg::RegHeight: prdata = {24'd0, cfg_q.area_height};
      ttw_pkg::RegPCol:   prdata = {24'd0, cfg_q.probe_col};
      ttw_pkg::RegPRow:   prdata = {24'd0, cfg_q.probe_row};
      ttw_pkg::RegPEn:    prdata = {31'd0, cfg_q.probe_enable};
      ttw_pkg::RegBreak:  prdata = {31'd0, cfg_q.after_break};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/text_word_wrap_layout.sv @@
// Top level: word-wrapping text layout sequencer with result hold stage.
//
//  channel  | dir | handshake      | payload
//  in_i     | in  | valid/ready    | text_byte, begin_page
//  out_o    | out | valid/ready    | cell run or status, run_last
//  apb      | in  | psel/penable   | eight configuration registers
//
// Each item runs through an accept step, decision steps, one step per replayed
// glyph of a wrapped word and a closing step. Reset clears the layout state;
// the word store needs no clearing. A result waiting on a busy output slot
// holds the sequencer; ready is high only between items.
module text_word_wrap_layout (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttw_in_if.sink       in_i,
  ttw_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_CHK, S_RF1, S_RF2, S_REPLAY, S_TRIM, S_BODY,
    S_Z2, S_ZF, S_NL, S_NLCHK, S_END
  } state_e;

  localparam int IdxW = ttw_pkg::IdxW;

  ttw_pkg::cfg_t cfg;

  ttw_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  state_e       state_q, state_d;
  logic [7:0]   b_q, b_d;
  logic [31:0]  off_q, off_d;
  logic         wrap_q, wrap_d;
  logic [5:0]   n_q, n_d, i_q, i_d;
  logic [7:0]   col_q, col_d, row_q, row_d;
  logic [5:0]   wlen_q, wlen_d, ssc_q, ssc_d;
  logic [31:0]  wso_q, wso_d, boff_q, boff_d;
  logic         ss_q, ss_d, rfp_q, rfp_d, trim_q, trim_d, crp_q, crp_d;
  logic         pover_q, pover_d;
  logic [32:0]  phit_q, phit_d;
  ttw_pkg::res_t hold_q, hold_d, out_q, res;
  logic         hold_v_q, hold_v_d, ov_q, last_q;
  logic         em, stall, slot_ok;

  logic [13:0]  wg_q [ttw_pkg::MaxWidth];
  logic         wg_we;
  logic [IdxW-1:0] wg_idx;
  logic [13:0]  g;
  logic [5:0]   w;
  logic [7:0]   h;
  logic [8:0]   ac, ar;
  logic         hit;

  assign w = (cfg.area_width > 6'(ttw_pkg::MaxWidth)) ? 6'(ttw_pkg::MaxWidth)
                                                       : cfg.area_width;
  assign h   = cfg.area_height;
  assign g   = ttw_pkg::glyph_of(b_q);
  assign ac  = {1'b0, cfg.area_left} + {1'b0, col_q};
  assign ar  = {1'b0, cfg.area_top} + {1'b0, row_q};
  assign hit = cfg.probe_enable && ac == {1'b0, cfg.probe_col} &&
               ar == {1'b0, cfg.probe_row};
  assign slot_ok = !ov_q || out_o.ready;
  assign stall   = (em || state_q == S_END) && hold_v_q && !slot_ok;

  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid        = ov_q;
  assign out_o.cell_col     = out_q.cell_col;
  assign out_o.cell_row     = out_q.cell_row;
  assign out_o.run_cols     = out_q.run_cols;
  assign out_o.run_rows     = out_q.run_rows;
  assign out_o.glyph_code   = out_q.glyph_code;
  assign out_o.page_done    = out_q.page_done;
  assign out_o.next_offset  = out_q.next_offset;
  assign out_o.probe_found  = out_q.probe_found;
  assign out_o.probe_offset = out_q.probe_offset;
  assign out_o.run_last     = last_q;

  always_comb begin
    state_d = state_q; b_d = b_q; off_d = off_q; wrap_d = wrap_q; n_d = n_q; i_d = i_q;
    col_d = col_q; row_d = row_q; wlen_d = wlen_q; ssc_d = ssc_q; wso_d = wso_q;
    boff_d = boff_q; ss_d = ss_q; rfp_d = rfp_q; trim_d = trim_q; crp_d = crp_q;
    pover_d = pover_q; phit_d = phit_q; hold_d = hold_q; hold_v_d = hold_v_q;
    em = 1'b0; res = '0; wg_we = 1'b0; wg_idx = wlen_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          b_d = in_i.text_byte;
          if (in_i.begin_page) begin
            row_d = 8'd0; col_d = 8'd0; ss_d = 1'b0; ssc_d = 6'd0; wlen_d = 6'd0;
            wso_d = 32'd0; boff_d = 32'd0; rfp_d = 1'b0; crp_d = 1'b0;
            pover_d = 1'b0; phit_d = 33'd0; trim_d = !cfg.after_break;
          end
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        if (pover_q || w == 6'd0 || h == 8'd0) begin
          em = 1'b1; res.page_done = 1'b1; res.next_offset = boff_q;
          pover_d = 1'b1; state_d = S_END;
        end else begin
          off_d = boff_q; boff_d = boff_q + 32'd1;
          if (crp_q) begin
            crp_d = 1'b0;
            if (b_q == ttw_pkg::ChLf) begin
              if (row_q >= h) begin
                em = 1'b1; res.next_offset = boff_q + 32'd1;
              end
              state_d = S_END;
            end else if (row_q >= h) begin
              em = 1'b1; res.next_offset = boff_q; state_d = S_END;
            end else begin
              state_d = S_TRIM;
            end
          end else if (rfp_q) begin
            rfp_d = 1'b0;
            wrap_d = ss_q && g != 14'd0 && wlen_q != 6'd0 && wlen_q < w && ssc_q < w;
            state_d = S_RF1;
          end else if (row_q >= h) begin
            em = 1'b1; res.next_offset = boff_q; state_d = S_END;
          end else if (col_q >= {2'b0, w}) begin
            row_d = row_q + 8'd1; col_d = 8'd0; ss_d = 1'b0; ssc_d = 6'd0;
            wlen_d = 6'd0; state_d = S_CHK;
          end else begin
            state_d = S_TRIM;
          end
          if (em) begin
            res.page_done = 1'b1; pover_d = 1'b1; boff_d = res.next_offset;
          end
        end
        res.probe_found = phit_q[32]; res.probe_offset = phit_q[31:0];
      end
      S_CHK: begin
        if (row_q >= h) begin
          em = 1'b1; res.next_offset = off_q; state_d = S_END;
        end else begin
          state_d = S_TRIM;
        end
      end
      S_RF1: begin
        if (wrap_q) begin
          em = 1'b1; res.cell_col = cfg.area_left + {2'b0, ssc_q};
          res.cell_row = ar[7:0]; res.run_cols = w - ssc_q; res.run_rows = 8'd1;
        end
        row_d = row_q + 8'd1; state_d = S_RF2;
      end
      S_RF2: begin
        if (row_q >= h) begin
          em = 1'b1; res.next_offset = wrap_q ? wso_q : off_q; state_d = S_END;
        end else begin
          n_d = wlen_q; col_d = 8'd0; ss_d = 1'b0; ssc_d = 6'd0; wlen_d = 6'd0;
          trim_d = 1'b0; i_d = 6'd0;
          if (wrap_q) state_d = S_REPLAY;
          else if (b_q == ttw_pkg::ChSpace) state_d = S_END;
          else state_d = S_TRIM;
        end
      end
      S_REPLAY: begin
        if (i_q < n_q) begin
          if (hit) phit_d = {1'b1, wso_q + {26'd0, i_q}};
          em = 1'b1; res.cell_col = ac[7:0]; res.cell_row = ar[7:0];
          res.run_cols = 6'd1; res.run_rows = 8'd1; res.glyph_code = wg_q[i_q[IdxW-1:0]];
          col_d = col_q + 8'd1;
          if (col_q + 8'd1 >= {2'b0, w}) rfp_d = 1'b1;
          i_d = i_q + 6'd1;
        end else begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (trim_q) begin
          trim_d = 1'b0;
          state_d = (b_q == ttw_pkg::ChSpace) ? S_END : S_BODY;
        end else begin
          state_d = S_BODY;
        end
      end
      S_BODY: begin
        if (b_q == ttw_pkg::ChNul) begin
          if (off_q == 32'd0) begin
            em = 1'b1; res.next_offset = 32'd0; state_d = S_END;
          end else begin
            if (col_q < {2'b0, w}) begin
              em = 1'b1; res.cell_col = ac[7:0]; res.cell_row = ar[7:0];
              res.run_cols = w - col_q[5:0]; res.run_rows = 8'd1;
            end
            state_d = S_Z2;
          end
        end else if (b_q == ttw_pkg::ChCr || b_q == ttw_pkg::ChLf) begin
          if (col_q < {2'b0, w}) begin
            em = 1'b1; res.cell_col = ac[7:0]; res.cell_row = ar[7:0];
            res.run_cols = w - col_q[5:0]; res.run_rows = 8'd1;
          end
          state_d = S_NL;
        end else begin
          if (g == 14'd0) begin
            ss_d = 1'b1; ssc_d = col_q[5:0] + 6'd1; wlen_d = 6'd0; wso_d = off_q + 32'd1;
          end else if (ss_q) begin
            if (wlen_q < 6'(ttw_pkg::MaxWidth)) wg_we = 1'b1;
            wlen_d = wlen_q + 6'd1;
          end
          if (hit) phit_d = {1'b1, off_q};
          em = 1'b1; res.cell_col = ac[7:0]; res.cell_row = ar[7:0];
          res.run_cols = 6'd1; res.run_rows = 8'd1; res.glyph_code = g;
          col_d = col_q + 8'd1;
          if (col_q + 8'd1 >= {2'b0, w}) rfp_d = 1'b1;
          state_d = S_END;
        end
      end
      S_Z2: begin
        if ({1'b0, row_q} + 9'd1 < {1'b0, h}) begin
          em = 1'b1; res.cell_col = cfg.area_left; res.cell_row = ar[7:0] + 8'd1;
          res.run_cols = w; res.run_rows = h - row_q - 8'd1;
        end
        state_d = S_ZF;
      end
      S_ZF: begin
        em = 1'b1; res.next_offset = off_q + 32'd1; state_d = S_END;
      end
      S_NL: begin
        row_d = row_q + 8'd1; col_d = 8'd0; ss_d = 1'b0; ssc_d = 6'd0; wlen_d = 6'd0;
        if (b_q == ttw_pkg::ChCr) begin
          crp_d = 1'b1; state_d = S_END;
        end else begin
          state_d = S_NLCHK;
        end
      end
      S_NLCHK: begin
        if (row_q >= h) begin
          em = 1'b1; res.next_offset = off_q + 32'd1;
        end
        state_d = S_END;
      end
      S_END: begin
        hold_v_d = 1'b0; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (em && state_q != S_TOP && res.run_cols == 6'd0) begin
      res.page_done = 1'b1; res.probe_found = phit_q[32];
      res.probe_offset = phit_q[31:0]; pover_d = 1'b1; boff_d = res.next_offset;
    end
    if (em && res.run_cols != 6'd0) begin
      res.page_done = 1'b0; res.probe_found = 1'b0; res.probe_offset = 32'd0;
    end
    if (em) begin
      hold_d = res; hold_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wg_we && !stall) wg_q[wg_idx] <= g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; col_q <= 8'd0; row_q <= 8'd0; wlen_q <= 6'd0;
      ssc_q <= 6'd0; wso_q <= 32'd0; boff_q <= 32'd0; ss_q <= 1'b0;
      rfp_q <= 1'b0; trim_q <= 1'b0; crp_q <= 1'b0; pover_q <= 1'b0;
      phit_q <= 33'd0; hold_v_q <= 1'b0; ov_q <= 1'b0; last_q <= 1'b0;
      b_q <= 8'd0; off_q <= 32'd0; wrap_q <= 1'b0; n_q <= 6'd0; i_q <= 6'd0;
      hold_q <= '0; out_q <= '0;
    end else begin
      if (!stall) begin
        state_q <= state_d; b_q <= b_d; off_q <= off_d; wrap_q <= wrap_d;
        n_q <= n_d; i_q <= i_d; col_q <= col_d; row_q <= row_d; wlen_q <= wlen_d;
        ssc_q <= ssc_d; wso_q <= wso_d; boff_q <= boff_d; ss_q <= ss_d;
        rfp_q <= rfp_d; trim_q <= trim_d; crp_q <= crp_d; pover_q <= pover_d;
        phit_q <= phit_d; hold_q <= hold_d; hold_v_q <= hold_v_d;
      end
      if (!stall && (em || state_q == S_END) && hold_v_q) begin
        out_q  <= hold_q;
        last_q <= (state_q == S_END);
        ov_q   <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule
